>>> hdl/fwerl_pkg.sv
// Shared types, constants and helpers for the fixed-window event rate limiter.
package fwerl_pkg;

    localparam int TIME_W = 64;
    localparam int CNT_W = 64;
    localparam int BURST_W = 32;
    localparam int SEV_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 392;

    localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 64'd1000000000;
    localparam logic [BURST_W-1:0] BURST_LIMIT_RST = 32'd10;
    localparam logic [SEV_W-1:0] SEV_INVALID = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_BURST_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_INVALID = 2'd1,
        ST_SINK_FAIL = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic [SEV_W-1:0] event_severity;
        logic text_valid;
        logic sink_accepts;
    } t_event;

    typedef struct packed {
        t_status status;
        logic forwarded;
        logic [TIME_W-1:0] record_time;
        logic [SEV_W-1:0] record_severity;
        logic [CNT_W-1:0] drops_prior;
        logic [CNT_W-1:0] attempted_total;
        logic [CNT_W-1:0] suppressed_total;
        logic [CNT_W-1:0] emitted_total;
        logic [CNT_W-1:0] failure_total;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
        sat_inc = (&value) ? value : value + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

>>> hdl/fwerl_core.sv
// Rate limiter state and the single-pass decision logic for one event.
module fwerl_core
    import fwerl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_event              i_event,
    input  logic [TIME_W-1:0]   i_window_length,
    input  logic [BURST_W-1:0]  i_burst_limit,
    output t_result             o_result
);

    logic               r_started;
    logic [TIME_W-1:0]  r_window_start;
    logic [TIME_W-1:0]  r_last_time;
    logic [BURST_W-1:0] r_window_count;
    logic [CNT_W-1:0]   r_pending;
    logic [CNT_W-1:0]   r_attempted;
    logic [CNT_W-1:0]   r_suppressed;
    logic [CNT_W-1:0]   r_emitted;
    logic [CNT_W-1:0]   r_failure;

    logic               n_started;
    logic [TIME_W-1:0]  n_window_start;
    logic [TIME_W-1:0]  n_last_time;
    logic [BURST_W-1:0] n_window_count;
    logic [CNT_W-1:0]   n_pending;
    logic [CNT_W-1:0]   n_attempted;
    logic [CNT_W-1:0]   n_suppressed;
    logic [CNT_W-1:0]   n_emitted;
    logic [CNT_W-1:0]   n_failure;

    logic               invalid;
    logic               restart;
    logic [BURST_W-1:0] count_now;
    logic               over_limit;
    logic [TIME_W-1:0]  elapsed;

    always_comb begin
        elapsed = i_event.event_time - r_window_start;
        invalid = (i_event.event_severity == SEV_INVALID) || !i_event.text_valid
                  || (r_started && (i_event.event_time < r_last_time));
        restart = !r_started || (elapsed >= i_window_length);
        count_now = restart ? '0 : r_window_count;
        over_limit = count_now >= i_burst_limit;

        n_started = r_started;
        n_window_start = r_window_start;
        n_last_time = r_last_time;
        n_window_count = r_window_count;
        n_pending = r_pending;
        n_attempted = r_attempted;
        n_suppressed = r_suppressed;
        n_emitted = r_emitted;
        n_failure = r_failure;

        o_result = '0;
        o_result.status = ST_OK;

        if (invalid) begin
            o_result.status = ST_INVALID;
        end else begin
            n_attempted = sat_inc(r_attempted);
            n_started = 1'b1;
            n_last_time = i_event.event_time;
            if (restart) begin
                n_window_start = i_event.event_time;
            end
            if (over_limit) begin
                n_window_count = count_now;
                n_suppressed = sat_inc(r_suppressed);
                n_pending = sat_inc(r_pending);
            end else begin
                n_window_count = count_now + {{(BURST_W-1){1'b0}}, 1'b1};
                o_result.forwarded = 1'b1;
                o_result.record_time = i_event.event_time;
                o_result.record_severity = i_event.event_severity;
                o_result.drops_prior = r_pending;
                if (!i_event.sink_accepts) begin
                    n_failure = sat_inc(r_failure);
                    o_result.status = ST_SINK_FAIL;
                end else begin
                    n_pending = '0;
                    n_emitted = sat_inc(r_emitted);
                end
            end
        end

        o_result.attempted_total = n_attempted;
        o_result.suppressed_total = n_suppressed;
        o_result.emitted_total = n_emitted;
        o_result.failure_total = n_failure;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_window_start <= '0;
            r_last_time <= '0;
            r_window_count <= '0;
            r_pending <= '0;
            r_attempted <= '0;
            r_suppressed <= '0;
            r_emitted <= '0;
            r_failure <= '0;
        end else if (i_step) begin
            r_started <= n_started;
            r_window_start <= n_window_start;
            r_last_time <= n_last_time;
            r_window_count <= n_window_count;
            r_pending <= n_pending;
            r_attempted <= n_attempted;
            r_suppressed <= n_suppressed;
            r_emitted <= n_emitted;
            r_failure <= n_failure;
        end
    end

endmodule

>>> hdl/fixed_window_event_rate_limiter_unit.sv
// Top level of the fixed-window event rate limiter: ports, config and beat registers.
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   s_axis_tdata[71:0]
//   m_axis    out        m_axis_tvalid / m_axis_tready   m_axis_tdata[391:0]
//   cfg       in         i_cfg_we                        i_cfg_index, i_cfg_data[63:0]
//
// One beat per cycle unless m_axis stalls; beats pass the input register, then the result register.
// The rate is set by the single decision pass between the input and result registers.
// Reset is synchronous: counters, window state and valid flags clear, registers
// return to window 1000000000 and burst 10. A stalled m_axis holds its beat;
// the input register takes at most one more beat, then s_axis_tready stays low.
module fixed_window_event_rate_limiter_unit
    import fwerl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // event_time[63:0], event_severity[65:64], text_valid[66], sink_accepts[67], zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], forwarded[2], record_time[66:3], record_severity[68:67],
    // drops_prior[132:69], attempted_total[196:133], suppressed_total[260:197],
    // emitted_total[324:261], failure_total[388:325], zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TIME_W-1:0]  r_window_length;
    logic [BURST_W-1:0] r_burst_limit;
    logic               r_in_vld;
    t_event             r_in;
    logic               r_out_vld;
    t_result            r_out;

    logic               advance;
    t_event             in_event;
    t_result            result;

    assign in_event.event_time = s_axis_tdata[63:0];
    assign in_event.event_severity = s_axis_tdata[65:64];
    assign in_event.text_valid = s_axis_tdata[66];
    assign in_event.sink_accepts = s_axis_tdata[67];

    assign advance = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_burst_limit <= BURST_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                CFG_BURST_LIMIT:   r_burst_limit <= i_cfg_data[BURST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= in_event;
        end
    end

    fwerl_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_event         (r_in),
        .i_window_length (r_window_length),
        .i_burst_limit   (r_burst_limit),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata = {3'b000,
                           r_out.failure_total,
                           r_out.emitted_total,
                           r_out.suppressed_total,
                           r_out.attempted_total,
                           r_out.drops_prior,
                           r_out.record_severity,
                           r_out.record_time,
                           r_out.forwarded,
                           r_out.status};

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the fixed-window event rate limiter unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fwerl_pkg::*;

    typedef enum int {MID_NONE, MID_RX_STALL, MID_TX_PAUSE} t_mid_action;

    class rate_limiter_scoreboard;
        logic [TIME_W-1:0]  window_len;
        logic [BURST_W-1:0] burst_max;
        bit                 started;
        logic [TIME_W-1:0]  win_start;
        logic [TIME_W-1:0]  prev_time;
        logic [BURST_W-1:0] win_count;
        logic [CNT_W-1:0]   pend_sup;
        logic [CNT_W-1:0]   n_attempted;
        logic [CNT_W-1:0]   n_suppressed;
        logic [CNT_W-1:0]   n_emitted;
        logic [CNT_W-1:0]   n_failed;
        t_result            expected_q[$];
        int                 mismatches;
        int                 n_results;
        int                 n_events;
        int                 n_rejected;
        int                 n_forwarded;
        int                 n_refused;
        int                 n_dropped;

        function new();
            window_len   = WINDOW_LENGTH_RST;
            burst_max    = BURST_LIMIT_RST;
            started      = 1'b0;
            win_start    = '0;
            prev_time    = '0;
            win_count    = '0;
            pend_sup     = '0;
            n_attempted  = '0;
            n_suppressed = '0;
            n_emitted    = '0;
            n_failed     = '0;
            mismatches   = 0;
            n_results    = 0;
            n_events     = 0;
            n_rejected   = 0;
            n_forwarded  = 0;
            n_refused    = 0;
            n_dropped    = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
            return (c == '1) ? c : c + CNT_W'(1);
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_WINDOW_LENGTH: window_len = value;
                CFG_BURST_LIMIT:   burst_max = value[BURST_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(t_event ev);
            t_result r;
            r = '0;
            r.status = ST_OK;
            n_events++;
            if (ev.event_severity == SEV_INVALID || !ev.text_valid ||
                (started && ev.event_time < prev_time)) begin
                r.status = ST_INVALID;
                n_rejected++;
            end else begin
                n_attempted = bump(n_attempted);
                if (!started || (ev.event_time - win_start) >= window_len) begin
                    win_start = ev.event_time;
                    win_count = '0;
                    started   = 1'b1;
                end
                prev_time = ev.event_time;
                if (win_count >= burst_max) begin
                    n_suppressed = bump(n_suppressed);
                    pend_sup     = bump(pend_sup);
                    n_dropped++;
                end else begin
                    win_count           = win_count + BURST_W'(1);
                    r.forwarded         = 1'b1;
                    r.record_time       = ev.event_time;
                    r.record_severity   = ev.event_severity;
                    r.drops_prior       = pend_sup;
                    n_forwarded++;
                    if (!ev.sink_accepts) begin
                        n_failed = bump(n_failed);
                        r.status = ST_SINK_FAIL;
                        n_refused++;
                    end else begin
                        pend_sup  = '0;
                        n_emitted = bump(n_emitted);
                    end
                end
            end
            r.attempted_total  = n_attempted;
            r.suppressed_total = n_suppressed;
            r.emitted_total    = n_emitted;
            r.failure_total    = n_failed;
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                if (mismatches < 10) begin
                    $display("ERROR: result %0d field %s: expected %0h, actual %0h",
                             n_results, name, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            t_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("ERROR: result beat with no pending event: %0h", beat);
                end
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                compare("status", 64'(want.status), 64'(beat[1:0]));
                compare("forwarded", 64'(want.forwarded), 64'(beat[2]));
                compare("record_time", want.record_time, beat[66:3]);
                compare("record_severity", 64'(want.record_severity), 64'(beat[68:67]));
                compare("drops_prior", want.drops_prior, beat[132:69]);
                compare("attempted_total", want.attempted_total, beat[196:133]);
                compare("suppressed_total", want.suppressed_total, beat[260:197]);
                compare("emitted_total", want.emitted_total, beat[324:261]);
                compare("failure_total", want.failure_total, beat[388:325]);
            end
            n_results++;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rate_limiter_scoreboard sb;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     stall_requests = 0;
    int                     stall_served = 0;
    int                     stall_left = 0;
    int                     n_settings = 0;
    logic [TIME_W-1:0]      now_time = '0;
    logic [TIME_W-1:0]      window_now = WINDOW_LENGTH_RST;

    fixed_window_event_rate_limiter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served  <= stall_requests;
            stall_left    <= 60;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_event(t_event'({s_axis_tdata[63:0], s_axis_tdata[65:64],
                                        s_axis_tdata[66], s_axis_tdata[67]}));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
        end
    end

    task automatic send_event(logic [TIME_W-1:0] t, logic [SEV_W-1:0] sev,
                              logic txt, logic acc);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, acc, txt, sev, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] next_gap();
        logic [TIME_W-1:0] span;
        span = (window_now > 64'd4000) ? 64'd1000 : window_now;
        case ($urandom_range(9))
            0, 1:    return '0;
            8:       return span + TIME_W'($urandom_range(span[31:0]));
            9:       return TIME_W'(3) * span + TIME_W'($urandom_range(9999));
            default: return TIME_W'($urandom_range(span[31:0] / 2));
        endcase
    endfunction

    task automatic send_random_event();
        logic [TIME_W-1:0]  t;
        logic [SEV_W-1:0]   sev;
        if ($urandom_range(99) < 5 && now_time > 64'd8) begin
            t = now_time - TIME_W'($urandom_range(1, 8));
        end else begin
            now_time = now_time + next_gap();
            t = now_time;
        end
        sev = ($urandom_range(99) < 8) ? SEV_INVALID : SEV_W'($urandom_range(2));
        send_event(t, sev, $urandom_range(99) >= 8, $urandom_range(99) >= 20);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_register(idx, value);
        if (idx == CFG_WINDOW_LENGTH) begin
            window_now = value;
        end
    endtask

    task automatic run_phase(logic [TIME_W-1:0] win, logic [BURST_W-1:0] burst,
                             int tx_pct, int rx_pct, int count, t_mid_action mid);
        int saved_tx;
        drain();
        cfg_write(CFG_WINDOW_LENGTH, win);
        cfg_write(CFG_BURST_LIMIT, CFG_DATA_W'(burst));
        n_settings++;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && mid == MID_RX_STALL) begin
                saved_tx = tx_idle_pct;
                tx_idle_pct = 0;
                stall_requests++;
                repeat (20) send_random_event();
                tx_idle_pct = saved_tx;
            end
            if (i == count / 2 && mid == MID_TX_PAUSE) begin
                drain();
            end
            send_random_event();
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;

        tx_idle_pct = 33;
        rx_idle_pct = 81;
        send_event(64'd0, 2'd0, 1'b1, 1'b1);
        send_event(64'd5, SEV_INVALID, 1'b1, 1'b1);
        send_event(64'd5, 2'd1, 1'b0, 1'b1);
        send_event(64'd5, 2'd2, 1'b1, 1'b0);
        send_event(64'd5, 2'd1, 1'b1, 1'b1);
        for (int i = 0; i < 7; i++) begin
            send_event(64'd20 + TIME_W'(i), SEV_W'(i % 3), 1'b1, 1'b1);
        end
        repeat (3) send_event(64'd30, 2'd2, 1'b1, 1'b1);
        send_event(64'd3, 2'd0, 1'b1, 1'b1);
        send_event(WINDOW_LENGTH_RST, 2'd1, 1'b1, 1'b1);
        send_event(WINDOW_LENGTH_RST + 64'd1, 2'd2, 1'b1, 1'b0);
        now_time = WINDOW_LENGTH_RST + 64'd1;

        run_phase(64'd1, 32'd1, 33, 81, 80, MID_NONE);
        run_phase(64'd200, 32'd4, 33, 81, 90, MID_RX_STALL);
        run_phase(64'd1000, 32'hFFFF_FFFF, 81, 33, 80, MID_TX_PAUSE);
        run_phase(64'd300, 32'd8, 81, 33, 60, MID_NONE);
        run_phase(64'd300, 32'd2, 0, 0, 80, MID_RX_STALL);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 0, 0, 90, MID_NONE);

        send_event(64'hFFFF_FFFF_FFFF_FFFE, 2'd2, 1'b1, 1'b1);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 2'd1, 1'b1, 1'b1);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 1'b1, 1'b0);
        send_event(64'hFFFF_FFFF_FFFF_FFF8, 2'd0, 1'b1, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);

        if (sb.outstanding() != 0) begin
            $display("ERROR: %0d expected results never arrived", sb.outstanding());
        end
        $display("Run: %0d events over %0d register settings, %0d rejected as invalid",
                 sb.n_events, n_settings, sb.n_rejected);
        $display("     %0d forwarded (%0d refused by the sink), %0d suppressed by the limit",
                 sb.n_forwarded, sb.n_refused, sb.n_dropped);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("fixed_window_event_rate_limiter_unit test passed");
        end else begin
            $display("fixed_window_event_rate_limiter_unit test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ERROR: timeout");
        $display("fixed_window_event_rate_limiter_unit test failed");
        $finish;
    end

endmodule
